@@ hw/rtl/i64alu_pkg.sv @@
// ----------------------------------------------------------------------------
// i64alu_pkg
// Shared types and constants of the 64-bit integer ALU.
// ----------------------------------------------------------------------------
package i64alu_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int ACTION_W       = 4;
	localparam int PORT_W         = 64;
	localparam int CMP_W          = 2;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [ACTION_W-1:0] ACT_ADD  = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_SUB  = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_MUL  = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_UDIV = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_SDIV = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_UCMP = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_SCMP = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_SHL  = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_LSHR = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_ASHR = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_NEG  = 4'd10;
	localparam logic [ACTION_W-1:0] ACT_ABS  = 4'd11;

	localparam logic [CMP_W-1:0] CMP_LT = 2'b11;
	localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
	localparam logic [CMP_W-1:0] CMP_GT = 2'b01;

	// Unit classes chosen by the front end.
	typedef enum logic [1:0] {
		CLS_FAST = 2'd0,
		CLS_MUL  = 2'd1,
		CLS_DIV  = 2'd2,
		CLS_NONE = 2'd3
	} unit_class_t;

endpackage

@@ hw/rtl/i64alu_front.sv @@
// ----------------------------------------------------------------------------
// i64alu_front
// Accepts transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module i64alu_front #(
	parameter int DATA_WIDTH = i64alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [i64alu_pkg::ACTION_W-1:0]  action,
	input  logic [i64alu_pkg::PORT_W-1:0]    operand_a,
	input  logic [i64alu_pkg::PORT_W-1:0]    operand_b,
	output logic                             q_valid,
	input  logic                             q_take,
	output i64alu_pkg::unit_class_t          q_cls,
	output logic [i64alu_pkg::ACTION_W-1:0]  q_action,
	output logic [DATA_WIDTH-1:0]            q_a,
	output logic [DATA_WIDTH-1:0]            q_b,
	output logic                             q_big
);
	localparam int D  = i64alu_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);

	i64alu_pkg::unit_class_t        cls_q [D];
	logic [i64alu_pkg::ACTION_W-1:0] act_q [D];
	logic [DATA_WIDTH-1:0]           a_q   [D];
	logic [DATA_WIDTH-1:0]           b_q   [D];
	logic                            big_q [D];
	logic [PW-1:0]                   wr_q, rd_q;
	logic [PW:0]                     cnt_q;
	i64alu_pkg::unit_class_t         cls;
	logic                            big;
	logic                            wr_en, rd_en;

	always_comb begin
		case (action)
			i64alu_pkg::ACT_MUL:  cls = i64alu_pkg::CLS_MUL;
			i64alu_pkg::ACT_UDIV,
			i64alu_pkg::ACT_SDIV: cls = i64alu_pkg::CLS_DIV;
			i64alu_pkg::ACT_ADD, i64alu_pkg::ACT_SUB, i64alu_pkg::ACT_UCMP,
			i64alu_pkg::ACT_SCMP, i64alu_pkg::ACT_SHL, i64alu_pkg::ACT_LSHR,
			i64alu_pkg::ACT_ASHR, i64alu_pkg::ACT_NEG,
			i64alu_pkg::ACT_ABS:  cls = i64alu_pkg::CLS_FAST;
			default:              cls = i64alu_pkg::CLS_NONE;
		endcase
	end

	// Shift counts of DATA_WIDTH or more saturate.
	assign big = (operand_b >= i64alu_pkg::PORT_W'(DATA_WIDTH));

	assign full    = (cnt_q == (PW+1)'(D));
	assign q_valid = (cnt_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cls_q[wr_q] <= cls;
			act_q[wr_q] <= action;
			a_q[wr_q]   <= operand_a[DATA_WIDTH-1:0];
			b_q[wr_q]   <= operand_b[DATA_WIDTH-1:0];
			big_q[wr_q] <= big;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= (wr_q == PW'(D-1)) ? '0 : wr_q + 1'b1;
			if (rd_en) rd_q <= (rd_q == PW'(D-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

	assign q_cls    = cls_q[rd_q];
	assign q_action = act_q[rd_q];
	assign q_a      = a_q[rd_q];
	assign q_b      = b_q[rd_q];
	assign q_big    = big_q[rd_q];

endmodule

@@ hw/rtl/i64alu_div.sv @@
// ----------------------------------------------------------------------------
// i64alu_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module i64alu_div #(
	parameter int DATA_WIDTH = i64alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	input  logic                  negate,
	output logic                  busy,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient
);
	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q, busy_q, done_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;

	assign trial = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			neg_q <= negate;
		end else if (busy_q) begin
			if (!diff[DATA_WIDTH]) begin
				rem_q <= diff[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? ('0 - quo_q) : quo_q;

endmodule

@@ hw/rtl/i64alu_back.sv @@
// ----------------------------------------------------------------------------
// i64alu_back
// Executes queued operations and holds the result in an output register.
// ----------------------------------------------------------------------------
module i64alu_back #(
	parameter int DATA_WIDTH = i64alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_take,
	input  i64alu_pkg::unit_class_t          q_cls,
	input  logic [i64alu_pkg::ACTION_W-1:0]  q_action,
	input  logic [DATA_WIDTH-1:0]            q_a,
	input  logic [DATA_WIDTH-1:0]            q_b,
	input  logic                             q_big,
	output logic                             empty,
	input  logic                             pop,
	output logic [i64alu_pkg::PORT_W-1:0]    result_value,
	output logic signed [i64alu_pkg::CMP_W-1:0] compare_result,
	output logic                             divide_by_zero
);
	localparam int SW = $clog2(DATA_WIDTH);
	localparam int PW = i64alu_pkg::PORT_W;
	localparam int HW = i64alu_pkg::PORT_W / 2;

	// Multiply steps: low by low, low by high, high by low.
	localparam logic [1:0] MUL_LL = 2'd0;
	localparam logic [1:0] MUL_LH = 2'd1;
	localparam logic [1:0] MUL_HL = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL  = 2'd1,
		ST_DIV  = 2'd2
	} state_t;

	state_t                       state_q;
	logic                         out_valid_q;
	logic [DATA_WIDTH-1:0]        res_q;
	logic [i64alu_pkg::CMP_W-1:0] cmp_q;
	logic                         dz_q;
	logic [PW-1:0]                mul_a_q, mul_b_q, mul_acc_q;
	logic [1:0]                   mul_step_q;

	logic                         out_free;
	logic                         out_set;
	logic [DATA_WIDTH-1:0]        fast_res;
	logic [i64alu_pkg::CMP_W-1:0] fast_cmp;
	logic [SW-1:0]                sh;
	logic                         a_neg, b_neg, sdiv;
	logic [DATA_WIDTH-1:0]        neg_a, mag_a, mag_b, ux, uy;
	logic                         div_start, div_busy, div_done;
	logic [DATA_WIDTH-1:0]        div_quo;
	logic                         is_div_zero;
	logic [HW-1:0]                mul_x, mul_y;
	logic [PW-1:0]                mul_prod, mul_term, mul_sum;

	assign out_free = !out_valid_q || pop;
	assign sh       = q_b[SW-1:0];
	assign a_neg    = q_a[DATA_WIDTH-1];
	assign b_neg    = q_b[DATA_WIDTH-1];
	assign neg_a    = '0 - q_a;
	assign mag_a    = a_neg ? neg_a : q_a;
	assign mag_b    = b_neg ? ('0 - q_b) : q_b;
	assign sdiv     = (q_action == i64alu_pkg::ACT_SDIV);
	assign is_div_zero = (q_b == '0);

	// Signed compare flips the sign bits and compares unsigned.
	always_comb begin
		ux = q_a;
		uy = q_b;
		if (q_action == i64alu_pkg::ACT_SCMP) begin
			ux[DATA_WIDTH-1] = !q_a[DATA_WIDTH-1];
			uy[DATA_WIDTH-1] = !q_b[DATA_WIDTH-1];
		end
	end

	always_comb begin
		fast_res = '0;
		fast_cmp = i64alu_pkg::CMP_EQ;
		case (q_action)
			i64alu_pkg::ACT_ADD: fast_res = q_a + q_b;
			i64alu_pkg::ACT_SUB: fast_res = q_a - q_b;
			i64alu_pkg::ACT_UCMP, i64alu_pkg::ACT_SCMP: begin
				if (ux > uy)      fast_cmp = i64alu_pkg::CMP_GT;
				else if (ux < uy) fast_cmp = i64alu_pkg::CMP_LT;
			end
			i64alu_pkg::ACT_SHL:  fast_res = q_big ? '0 : (q_a << sh);
			i64alu_pkg::ACT_LSHR: fast_res = q_big ? '0 : (q_a >> sh);
			i64alu_pkg::ACT_ASHR:
				fast_res = q_big ? {DATA_WIDTH{a_neg}} : DATA_WIDTH'($signed(q_a) >>> sh);
			i64alu_pkg::ACT_NEG:  fast_res = neg_a;
			i64alu_pkg::ACT_ABS:  fast_res = mag_a;
			default:              fast_res = '0;
		endcase
	end

	// Take the head item when idle and the output register will be free.
	always_comb begin
		q_take    = 1'b0;
		div_start = 1'b0;
		if (state_q == ST_IDLE && q_valid && out_free) begin
			q_take = 1'b1;
			if (q_cls == i64alu_pkg::CLS_DIV && !is_div_zero) div_start = 1'b1;
		end
	end

	// A result is written when a fast or unused-class item or a zero divide is taken,
	// at the last multiply step, or when the divider finishes.
	always_comb begin
		out_set = 1'b0;
		if (state_q == ST_IDLE && q_take) begin
			out_set = (q_cls != i64alu_pkg::CLS_MUL) &&
				!(q_cls == i64alu_pkg::CLS_DIV && !is_div_zero);
		end else if (state_q == ST_MUL) begin
			out_set = (mul_step_q == MUL_HL);
		end else if (state_q == ST_DIV) begin
			out_set = div_done;
		end
	end

	i64alu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sdiv ? mag_a : q_a),
		.divisor  (sdiv ? mag_b : q_b),
		.negate   (sdiv && (a_neg != b_neg)),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The low word of the product is built from three half-width products,
	// one per cycle; the high by high product falls outside the low word.
	always_comb begin
		case (mul_step_q)
			MUL_LL: begin
				mul_x = mul_a_q[HW-1:0];
				mul_y = mul_b_q[HW-1:0];
			end
			MUL_LH: begin
				mul_x = mul_a_q[HW-1:0];
				mul_y = mul_b_q[PW-1:HW];
			end
			default: begin
				mul_x = mul_a_q[PW-1:HW];
				mul_y = mul_b_q[HW-1:0];
			end
		endcase
		mul_prod = mul_x * mul_y;
		mul_term = (mul_step_q == MUL_LL) ? mul_prod : {mul_prod[HW-1:0], {HW{1'b0}}};
		mul_sum  = mul_acc_q + mul_term;
	end

	always_ff @(posedge clk) begin
		if (q_take && q_cls == i64alu_pkg::CLS_MUL) begin
			mul_a_q    <= PW'(q_a);
			mul_b_q    <= PW'(q_b);
			mul_acc_q  <= '0;
			mul_step_q <= MUL_LL;
		end else if (state_q == ST_MUL) begin
			mul_acc_q  <= mul_sum;
			mul_step_q <= mul_step_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			cmp_q       <= '0;
			dz_q        <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (q_take) begin
						case (q_cls)
							i64alu_pkg::CLS_MUL: state_q <= ST_MUL;
							i64alu_pkg::CLS_DIV: begin
								if (is_div_zero) begin
									res_q <= '1;
									cmp_q <= i64alu_pkg::CMP_EQ;
									dz_q  <= 1'b1;
								end else begin
									state_q <= ST_DIV;
								end
							end
							default: begin
								res_q <= fast_res;
								cmp_q <= fast_cmp;
								dz_q  <= 1'b0;
							end
						endcase
					end
				end
				ST_MUL: begin
					if (mul_step_q == MUL_HL) begin
						res_q   <= mul_sum[DATA_WIDTH-1:0];
						cmp_q   <= i64alu_pkg::CMP_EQ;
						dz_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q   <= div_quo;
						cmp_q   <= i64alu_pkg::CMP_EQ;
						dz_q    <= 1'b0;
						state_q <= ST_IDLE;
					end else if (!div_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty          = !out_valid_q;
	assign result_value   = i64alu_pkg::PORT_W'(res_q);
	assign compare_result = cmp_q;
	assign divide_by_zero = dz_q;

endmodule

@@ hw/rtl/int64_alu.sv @@
// ----------------------------------------------------------------------------
// int64_alu
// 64-bit integer ALU with add, subtract, multiply, divide, compare, shifts.
// ----------------------------------------------------------------------------
// The input channel is a queue: a transaction is accepted when push is high
// and full is low, carrying action, operand_a and operand_b. The output
// channel is also a queue: while empty is low the oldest result is on
// result_value, compare_result and divide_by_zero, and it is taken when pop
// is high.
// A two-entry front queue decouples acceptance from execution. The back end
// takes one queued transaction at a time. Add, subtract, compares, shifts,
// negate and absolute value are computed combinationally from the queue head
// and written to the output register when taken. Multiply runs three steps
// on a half-width multiplier. Division runs on a radix-2 divider, one
// quotient bit per cycle, and holds the back end until it finishes; a zero
// divisor skips the divider and returns all ones when taken.
// Sustained rate: one transaction per cycle for the actions above while pop
// stays high; a multiply or divide holds the back end until it finishes.
// Reset empties the queue and the output register and stops the divider.
// When the receiver stalls, the output register holds its result, the back
// end stops, the queue fills and full rises.
// ----------------------------------------------------------------------------
module int64_alu #(
	parameter int DATA_WIDTH = i64alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [i64alu_pkg::ACTION_W-1:0]      action,
	input  logic [i64alu_pkg::PORT_W-1:0]        operand_a,
	input  logic [i64alu_pkg::PORT_W-1:0]        operand_b,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [i64alu_pkg::PORT_W-1:0]        result_value,
	output logic signed [i64alu_pkg::CMP_W-1:0]  compare_result,
	output logic                                 divide_by_zero
);
	// Queue head as seen by the back end.
	logic                            q_valid, q_take, q_big;
	i64alu_pkg::unit_class_t         q_cls;
	logic [i64alu_pkg::ACTION_W-1:0] q_action;
	logic [DATA_WIDTH-1:0]           q_a, q_b;

	i64alu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_cls     (q_cls),
		.q_action  (q_action),
		.q_a       (q_a),
		.q_b       (q_b),
		.q_big     (q_big)
	);

	i64alu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_take         (q_take),
		.q_cls          (q_cls),
		.q_action       (q_action),
		.q_a            (q_a),
		.q_b            (q_b),
		.q_big          (q_big),
		.empty          (empty),
		.pop            (pop),
		.result_value   (result_value),
		.compare_result (compare_result),
		.divide_by_zero (divide_by_zero)
	);

endmodule

@@ hw/rtl/int64_alu_checker.sv @@
// ----------------------------------------------------------------------------
// int64_alu_checker
// Port-level checks of the ALU, bound to the top level.
// ----------------------------------------------------------------------------
module int64_alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [63:0] result_value,
	input logic [1:0]  compare_result,
	input logic        divide_by_zero
);
	// A waiting result stays until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_value)))
		else $error("result changed while stalled");

	// The compare code is never the unused pattern.
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (compare_result != 2'b10))
		else $error("bad compare code");

	// Compare and divide-by-zero outputs never both flag.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && divide_by_zero) |-> (compare_result == 2'b00))
		else $error("divide by zero with compare result");

	// Divide by zero always returns all ones.
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && divide_by_zero) |-> (result_value == '1))
		else $error("divide by zero result not all ones");

	// After reset the input side is open and no result is waiting.
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> (!full && empty))
		else $error("not idle after reset");

endmodule

bind int64_alu int64_alu_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.full           (full),
	.empty          (empty),
	.pop            (pop),
	.result_value   (result_value),
	.compare_result (compare_result),
	.divide_by_zero (divide_by_zero)
);

@@ dv/tb_int64_alu.sv @@
// ----------------------------------------------------------------------------
// tb_int64_alu
// Self-checking testbench of the 64-bit integer ALU.
// ----------------------------------------------------------------------------
// A directed table covers operand extremes, every action, divide by zero,
// signed division overflow, abs of the most negative value, large shift
// counts and an unused action code. Random transactions follow. Every accepted
// transaction is predicted and the expectation is queued; every popped
// result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_int64_alu;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          W       = 64;
	localparam logic [63:0] ALL_ONE = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
	localparam logic [3:0]  ACT_UNUSED = 4'd12;
	localparam logic [3:0]  ACT_TOP    = 4'd15;
	localparam int          N_RANDOM  = 2000;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  cmp;
		logic        dz;
	} alu_result_t;

	// One directed row: the operation, its operands, and an optional typed-in
	// expectation used where the answer is plain to see.
	typedef struct {
		logic [3:0]  act;
		logic [63:0] a;
		logic [63:0] b;
		bit          fixed;
		alu_result_t res;
	} alu_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [3:0]  action;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic        empty;
	logic        pop;
	logic [63:0] result_value;
	logic signed [1:0] compare_result;
	logic        divide_by_zero;

	alu_result_t pending_results[$];
	alu_row_t    directed[$];
	int          fail_count = 0;
	bit          stim_done  = 0;

	int64_alu i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.empty         (empty),
		.pop           (pop),
		.result_value  (result_value),
		.compare_result(compare_result),
		.divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] twos_neg(logic [63:0] v);
		return 64'd0 - v;
	endfunction

	function automatic logic [63:0] abs_of(logic [63:0] v);
		return v[63] ? twos_neg(v) : v;
	endfunction

	function automatic logic [1:0] order_of(logic [63:0] x, logic [63:0] y);
		if (x > y)
			return i64alu_pkg::CMP_GT;
		if (x < y)
			return i64alu_pkg::CMP_LT;
		return i64alu_pkg::CMP_EQ;
	endfunction

	// Computes the result of one transaction.
	function automatic alu_result_t alu_compute(logic [3:0] act, logic [63:0] a,
			logic [63:0] b);
		alu_result_t r;
		logic [63:0] q;
		r = '0;
		case (act)
			i64alu_pkg::ACT_ADD: r.value = a + b;
			i64alu_pkg::ACT_SUB: r.value = a - b;
			i64alu_pkg::ACT_MUL: r.value = a * b;
			i64alu_pkg::ACT_UDIV: begin
				if (b == 0) begin
					r.value = ALL_ONE;
					r.dz    = 1'b1;
				end else begin
					r.value = a / b;
				end
			end
			i64alu_pkg::ACT_SDIV: begin
				if (b == 0) begin
					r.value = ALL_ONE;
					r.dz    = 1'b1;
				end else begin
					q = abs_of(a) / abs_of(b);
					r.value = (a[63] != b[63]) ? twos_neg(q) : q;
				end
			end
			i64alu_pkg::ACT_UCMP: r.cmp = order_of(a, b);
			i64alu_pkg::ACT_SCMP: r.cmp = order_of(a ^ MIN_NEG, b ^ MIN_NEG);
			i64alu_pkg::ACT_SHL:  r.value = (b >= W) ? 64'd0 : a << b[5:0];
			i64alu_pkg::ACT_LSHR: r.value = (b >= W) ? 64'd0 : a >> b[5:0];
			i64alu_pkg::ACT_ASHR: begin
				if (b >= W)
					r.value = a[63] ? ALL_ONE : 64'd0;
				else
					r.value = $signed(a) >>> b[5:0];
			end
			i64alu_pkg::ACT_NEG: r.value = twos_neg(a);
			i64alu_pkg::ACT_ABS: r.value = abs_of(a);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic alu_row_t row(logic [3:0] act, logic [63:0] a, logic [63:0] b,
			bit fixed = 0, logic [63:0] v = 0, logic [1:0] c = 0, logic dz = 0);
		alu_row_t t;
		t.act   = act;
		t.a     = a;
		t.b     = b;
		t.fixed = fixed;
		t.res   = '{value: v, cmp: c, dz: dz};
		return t;
	endfunction

	// Random operand with a bias toward corner values.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return ALL_ONE;
			2: return MIN_NEG;
			3: return MAX_POS;
			4: return 64'($urandom_range(0, 70));
			5: return {$urandom, $urandom} >> $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Drives one transaction and holds it until the block accepts it. Push
	// stays high after acceptance until the next call replaces the data or
	// pauses.
	task automatic send(alu_row_t t);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		action    <= t.act;
		operand_a <= t.a;
		operand_b <= t.b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		// Accepted at this edge; record what should come back.
		pending_results.push_back(t.fixed ? t.res : alu_compute(t.act, t.a, t.b));
	endtask

	// Sender.
	initial begin
		alu_row_t t;
		push      = 1'b0;
		action    = '0;
		operand_a = '0;
		operand_b = '0;
		pop       = 1'b0;
		arst_n    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(row(i64alu_pkg::ACT_ADD, ALL_ONE, 64'd1, 1, 64'd0));
		directed.push_back(row(i64alu_pkg::ACT_ADD, MAX_POS, 64'd1, 1, MIN_NEG));
		directed.push_back(row(i64alu_pkg::ACT_SUB, 64'd0, 64'd1, 1, ALL_ONE));
		directed.push_back(row(i64alu_pkg::ACT_MUL, ALL_ONE, ALL_ONE, 1, 64'd1));
		directed.push_back(row(i64alu_pkg::ACT_MUL, 64'h1234_5678_9abc_def0,
			64'hfedc_ba98_7654_3211));
		directed.push_back(row(i64alu_pkg::ACT_UDIV, ALL_ONE, 64'd0, 1, ALL_ONE,
			i64alu_pkg::CMP_EQ, 1'b1));
		directed.push_back(row(i64alu_pkg::ACT_SDIV, MIN_NEG, 64'd0, 1, ALL_ONE,
			i64alu_pkg::CMP_EQ, 1'b1));
		directed.push_back(row(i64alu_pkg::ACT_UDIV, ALL_ONE, 64'd3));
		directed.push_back(row(i64alu_pkg::ACT_UDIV, 64'd5, ALL_ONE, 1, 64'd0));
		directed.push_back(row(i64alu_pkg::ACT_SDIV, MIN_NEG, ALL_ONE, 1, MIN_NEG));
		directed.push_back(row(i64alu_pkg::ACT_SDIV, twos_neg(64'd7), 64'd2, 1,
			twos_neg(64'd3)));
		directed.push_back(row(i64alu_pkg::ACT_UCMP, ALL_ONE, 64'd0, 1, 64'd0,
			i64alu_pkg::CMP_GT));
		directed.push_back(row(i64alu_pkg::ACT_SCMP, ALL_ONE, 64'd0, 1, 64'd0,
			i64alu_pkg::CMP_LT));
		directed.push_back(row(i64alu_pkg::ACT_SCMP, MIN_NEG, MIN_NEG, 1, 64'd0,
			i64alu_pkg::CMP_EQ));
		directed.push_back(row(i64alu_pkg::ACT_SHL, ALL_ONE, 64'd63, 1, MIN_NEG));
		directed.push_back(row(i64alu_pkg::ACT_SHL, ALL_ONE, 64'd64, 1, 64'd0));
		directed.push_back(row(i64alu_pkg::ACT_LSHR, ALL_ONE, MIN_NEG, 1, 64'd0));
		directed.push_back(row(i64alu_pkg::ACT_LSHR, MIN_NEG, 64'd63, 1, 64'd1));
		directed.push_back(row(i64alu_pkg::ACT_ASHR, MIN_NEG, 64'd63, 1, ALL_ONE));
		directed.push_back(row(i64alu_pkg::ACT_ASHR, MIN_NEG, ALL_ONE, 1, ALL_ONE));
		directed.push_back(row(i64alu_pkg::ACT_ASHR, MAX_POS, 64'd64, 1, 64'd0));
		directed.push_back(row(i64alu_pkg::ACT_NEG, 64'd1, 64'd0, 1, ALL_ONE));
		directed.push_back(row(i64alu_pkg::ACT_ABS, MIN_NEG, 64'd0, 1, MIN_NEG));
		directed.push_back(row(i64alu_pkg::ACT_ABS, ALL_ONE, 64'd0, 1, 64'd1));
		directed.push_back(row(ACT_TOP, ALL_ONE, ALL_ONE, 1, 64'd0));

		foreach (directed[i])
			send(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			// Midway, hold off until the block has drained completely.
			if (n == N_RANDOM / 2 && pending_results.size() != 0) begin
				push <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			t = row(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
			if (t.act >= ACT_UNUSED && $urandom_range(0, 3) != 0)
				t.act = 4'($urandom_range(0, int'(i64alu_pkg::ACT_ABS)));
			send(t);
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls on pop, with stall-free stretches.
	initial begin
		int stall;
		alu_result_t got;
		alu_result_t want;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got = '{value: result_value, cmp: compare_result, dz: divide_by_zero};
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction pending: %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						want.value, got.value);
					fail_count++;
				end
				if (got.cmp !== want.cmp) begin
					$display("%0t: compare_result expected %b actual %b", $time,
						want.cmp, got.cmp);
					fail_count++;
				end
				if (got.dz !== want.dz) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						want.dz, got.dz);
					fail_count++;
				end
			end
		end
	end

	// End of run: drain, then allow for a full divide latency before judging.
	initial begin
		wait (stim_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Worst case is about 2000 divides with both sides stalling the longest,
	// roughly 2 ms; this is ten times that.
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
